// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk_i while out of reset.
`define CVL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cvl assertion failed");
// Checked on every rising edge of clk_i, reset included.
`define CVL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cvl assertion failed");
`else
`define CVL_ASSERT(lbl, prop)
`define CVL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- sv/cvl_pkg.sv -----
// ---------------------------------------------------------------------------
// cvl_pkg
// Shared constants and types for the compacting value list.
// ---------------------------------------------------------------------------
package cvl_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int FW         = $clog2(DEPTH + 1);
  localparam int COUNT_W    = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  // one write port and one read port on the value store
  typedef struct packed {
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [AW-1:0]         raddr;
  } mem_req_t;

endpackage

// ----- sv/cvl_store.sv -----
// ---------------------------------------------------------------------------
// cvl_store
// Value store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module cvl_store
  import cvl_pkg::*;
(
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem_q [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cvl_seq.sv -----
// ---------------------------------------------------------------------------
// cvl_seq
// Request sequencer: fill count, scan with a shared comparator, shift-down.
// ---------------------------------------------------------------------------
module cvl_seq
  import cvl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            mode_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] rdata_i,
  output mem_req_t              mem_req_o,
  output logic                  busy_o,
  output logic                  done_o,
  output logic                  ok_o,
  output logic [FW-1:0]         fill_o
);

  state_e                state_q, state_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [FW-1:0]         idx_q, idx_d;    // next address to read
  logic [AW-1:0]         wr_q, wr_d;      // next address to write when shifting
  logic                  pend_q, pend_d;  // read data of idx_q-1 is valid
  logic                  ok_q, ok_d;
  logic                  rm_q, rm_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    wr_q  <= wr_d;
    rm_q  <= rm_d;
    val_q <= val_d;
  end

  // the one comparator, shared by search and remove
  assign hit = pend_q && (rdata_i == val_q);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    wr_d    = wr_q;
    pend_d  = pend_q;
    ok_d    = ok_q;
    rm_d    = rm_q;
    val_d   = val_q;
    done_o  = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wr_q;
    mem_req_o.wdata = rdata_i;
    mem_req_o.raddr = idx_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          val_d  = value_i;
          rm_d   = (mode_i == MODE_REMOVE);
          idx_d  = '0;
          pend_d = 1'b0;
          ok_d   = 1'b0;
          state_d = ST_RESP;
          unique case (mode_i)
            MODE_INSERT: begin
              if (fill_q < FW'(DEPTH)) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = fill_q[AW-1:0];
                mem_req_o.wdata = value_i;
                fill_d = fill_q + FW'(1);
                ok_d   = 1'b1;
              end
            end
            MODE_REMOVE, MODE_SEARCH: begin
              if (fill_q != '0) begin
                state_d = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (rm_q) begin
            // match sits at idx_q-1; first entry to move is idx_q
            wr_d    = AW'(idx_q - FW'(1));
            pend_d  = 1'b0;
            state_d = ST_SHIFT;
          end else begin
            ok_d    = 1'b1;
            state_d = ST_RESP;
          end
        end else if (idx_q == fill_q) begin
          state_d = ST_RESP;
        end else begin
          idx_d  = idx_q + FW'(1);
          pend_d = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (pend_q) begin
          mem_req_o.we = 1'b1;
          wr_d = wr_q + AW'(1);
        end
        if (idx_q < fill_q) begin
          idx_d  = idx_q + FW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            fill_d  = fill_q - FW'(1);
            ok_d    = 1'b1;
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign ok_o   = ok_q;
  assign fill_o = fill_q;

endmodule

// ----- sv/compacting_value_list.sv -----
// ---------------------------------------------------------------------------
// compacting_value_list
// Bag of up to DEPTH values packed at the front of a store, with fill count.
// ---------------------------------------------------------------------------
// Timing: done_o is high in the cycle after acceptance for insert and
//   clear; search and remove scan the list, and remove then shifts the
//   later entries down, through the single read port of the store, which
//   visits one entry per cycle for scan and shift.
// Throughput: one request at a time; busy is high from the cycle after
//   acceptance through the done_o cycle, and the next request can be
//   taken in the cycle after done_o.
// Reset: fill count cleared at once; store contents undefined, never read.
// Results are shown for one cycle on done_o; the receiver cannot stall.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module compacting_value_list
  import cvl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  done_o,
  output logic                  ok_o,
  output logic [COUNT_W-1:0]    count_o,
  output logic                  empty_res_o
);

  mem_req_t              mem_req;
  logic [VALUE_BITS-1:0] rdata;
  logic [FW-1:0]         fill;

  // Sequencer: owns the fill count and drives the store's single port pair.
  cvl_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .mode_i    (mode_i),
    .value_i   (value_i),
    .rdata_i   (rdata),
    .mem_req_o (mem_req),
    .busy_o    (busy),
    .done_o    (done_o),
    .ok_o      (ok_o),
    .fill_o    (fill)
  );

  // Store: entries below the fill count are always valid.
  cvl_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // count is the fill masked to its field width
  assign count_o     = COUNT_W'(fill);
  assign empty_res_o = (fill == '0);

  // Result strobe lasts one cycle only.
  `CVL_ASSERT(a_done_pulse, done_o |=> !done_o)
  // An accepted request makes the block busy on the next cycle.
  `CVL_ASSERT(a_start_busy, (start && !busy) |=> busy)
  // A result is only given while busy.
  `CVL_ASSERT(a_done_busy, done_o |-> busy)
  // Fill never exceeds the store depth.
  `CVL_ASSERT(a_fill_max, fill <= FW'(DEPTH))

endmodule

// ----- verif/compacting_value_list_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// compacting_value_list_tb
// Self-checking bench for the compacting value list. Requests are driven
// through the start/busy handshake. A scoreboard keeps its own copy of the
// packed list and fill count and predicts ok, count and empty for every
// accepted request. Each done_o strobe is checked against the oldest
// prediction. Directed edge cases run first, then a long random mix whose
// values are biased towards stored entries and near misses.
// ---------------------------------------------------------------------------
module compacting_value_list_tb;
  import cvl_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } outcome_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  req_start = 1'b0;
  mode_e                 req_mode  = MODE_INSERT;
  logic [VALUE_BITS-1:0] req_value = '0;
  logic                  busy;
  logic                  done;
  logic                  res_ok;
  logic [COUNT_W-1:0]    res_count;
  logic                  res_empty;

  // scoreboard copy of the list: packed entries below bag_fill
  logic [VALUE_BITS-1:0] bag_vals [DEPTH];
  int unsigned           bag_fill = 0;
  outcome_t              pending_outcomes [$];

  // values that recur, so duplicates and matches are common
  logic [VALUE_BITS-1:0] value_pool [8];

  int unsigned err_cnt     = 0;
  int unsigned checked_cnt = 0;
  int unsigned mode_cnt [4] = '{default: 0};
  int unsigned full_refusals = 0;
  int unsigned remove_hits   = 0;
  int unsigned remove_misses = 0;

  compacting_value_list u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (req_start),
    .busy        (busy),
    .mode_i      (req_mode),
    .value_i     (req_value),
    .done_o      (done),
    .ok_o        (res_ok),
    .count_o     (res_count),
    .empty_res_o (res_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("compacting_value_list_tb: errors");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor: applies one accepted request to the scoreboard list and
  // queues the result it must produce.
  // -------------------------------------------------------------------------
  function automatic void predict_request(mode_e m, logic [VALUE_BITS-1:0] v);
    int unsigned i;
    int unsigned hit;
    outcome_t    o;
    hit = bag_fill;
    for (i = 0; i < bag_fill; i++) begin
      if (hit == bag_fill && bag_vals[i] == v) hit = i;
    end
    o.ok = 1'b0;
    case (m)
      MODE_INSERT: begin
        if (bag_fill < DEPTH) begin
          bag_vals[bag_fill] = v;
          bag_fill++;
          o.ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      MODE_REMOVE: begin
        // lowest-indexed match goes, later entries close the hole
        if (hit < bag_fill) begin
          for (i = hit; i + 1 < bag_fill; i++) bag_vals[i] = bag_vals[i + 1];
          bag_fill--;
          o.ok = 1'b1;
          remove_hits++;
        end else begin
          remove_misses++;
        end
      end
      MODE_SEARCH: o.ok = (hit < bag_fill);
      default:     bag_fill = 0;   // clear: ok stays low
    endcase
    o.count = COUNT_W'(bag_fill);
    o.empty = (bag_fill == 0);
    pending_outcomes.push_back(o);
    mode_cnt[m]++;
  endfunction

  // -------------------------------------------------------------------------
  // Result checker: every done_o strobe is matched to the oldest prediction.
  // -------------------------------------------------------------------------
  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && done) begin
      if (pending_outcomes.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no request outstanding, expected none, %s",
                 $time, "got");
        $display("  ok=%0b count=%0d empty=%0b", res_ok, res_count, res_empty);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("ok", 32'(want.ok), 32'(res_ok));
        check_field("count", 32'(want.count), 32'(res_count));
        check_field("empty", 32'(want.empty), 32'(res_empty));
        checked_cnt++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender. start is left high after acceptance; the next request or a gap
  // replaces it in the same step, so it only ever gets one update per step.
  // -------------------------------------------------------------------------
  task automatic send_request(mode_e m, logic [VALUE_BITS-1:0] v);
    req_start <= 1'b1;
    req_mode  <= m;
    req_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(m, v);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n != 0) begin
      req_start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off new requests until every predicted result has been seen.
  task automatic pause_until_drained();
    req_start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  // Mostly stored values, pool values and single-bit near misses.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned sel;
    logic [VALUE_BITS-1:0] v;
    sel = $urandom_range(0, 5);
    v   = $urandom;
    if (sel <= 1) begin
      v = value_pool[$urandom_range(0, 7)];
    end else if (sel <= 3 && bag_fill != 0) begin
      v = bag_vals[$urandom_range(0, bag_fill - 1)];
    end else if (sel == 4 && bag_fill != 0) begin
      v = bag_vals[$urandom_range(0, bag_fill - 1)];
      v[$urandom_range(0, VALUE_BITS - 1)] ^= 1'b1;
    end
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Empty list, extreme values, duplicates and misses.
  task automatic test_edge_values();
    send_request(MODE_SEARCH, '0);
    send_request(MODE_REMOVE, '1);
    send_request(MODE_INSERT, '1);
    send_request(MODE_INSERT, '0);
    send_request(MODE_INSERT, '0);
    send_request(MODE_REMOVE, '0);         // first copy only
    send_request(MODE_SEARCH, '0);         // second copy still there
    send_request(MODE_REMOVE, {1'b1, {(VALUE_BITS - 1){1'b0}}});
    pause_until_drained();
  endtask

  // Fill to DEPTH, refused insert, head and tail removal, clear.
  task automatic test_full_list();
    while (bag_fill < DEPTH) send_request(MODE_INSERT, $urandom);
    send_request(MODE_INSERT, $urandom);
    send_request(MODE_REMOVE, bag_vals[0]);
    send_request(MODE_REMOVE, bag_vals[bag_fill - 1]);
    send_request(MODE_CLEAR, $urandom);
    pause_until_drained();
  endtask

  // Random mix in bursts; inserts outweigh removes so the list fills up,
  // with the odd clear to start over.
  task automatic test_random_mix(int unsigned n_req);
    int unsigned sent;
    int unsigned pick;
    mode_e       m;
    sent = 0;
    while (sent < n_req) begin
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(0, 99);
        if (pick < 42)      m = MODE_INSERT;
        else if (pick < 67) m = MODE_REMOVE;
        else if (pick < 97) m = MODE_SEARCH;
        else                m = MODE_CLEAR;
        send_request(m, pick_value());
        sent++;
      end
      idle_gap(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8));
      if ($urandom_range(0, 19) == 0) pause_until_drained();
    end
  endtask

  initial begin
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int k = 2; k < 8; k++) value_pool[k] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_full_list();
    test_random_mix(1000);

    // drain, then watch a while longer for stray strobes
    pause_until_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived, expected 0 outstanding",
               $time, pending_outcomes.size());
    end

    $display("run: %0d results checked; insert %0d, remove %0d, search %0d, clear %0d",
             checked_cnt, mode_cnt[MODE_INSERT], mode_cnt[MODE_REMOVE],
             mode_cnt[MODE_SEARCH], mode_cnt[MODE_CLEAR]);
    $display("run: %0d inserts refused on a full list, removes %0d matched / %0d missed",
             full_refusals, remove_hits, remove_misses);
    if (err_cnt == 0) begin
      $display("compacting_value_list_tb: clean");
    end else begin
      $display("compacting_value_list_tb: errors");
    end
    $finish;
  end

endmodule
